>>> hw/rtl/sact_pkg.sv
// Shared types, constants and codes for the set-associative cache tag controller.
package sact_pkg;

   // Geometry: sets are a power of two, set by their index width
   localparam int SET_BITS    = 6;
   localparam int SETS        = 1 << SET_BITS;
   localparam int SET_W       = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAYS        = 8;
   localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WCNT_W      = (WAYS > 1) ? $clog2(WAYS + 1) : 1;

   // Access fields
   localparam int ADDR_W      = 48;
   localparam int BLOCK_SHIFT = 6;
   localparam int TAG_W       = ADDR_W - BLOCK_SHIFT;
   localparam int RANK_W      = 3;
   localparam int CNT_W       = 32;
   localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
   localparam logic [RANK_W:0]   RANK_ALL = 4'd8;

   // Register file
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WBACK    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 2'd3;

   // Field codes
   localparam logic POLICY_LRU   = 1'b0;
   localparam logic POLICY_FIFO  = 1'b1;
   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // One way of a set
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic              valid;
      logic              dirty;
      logic [RANK_W-1:0] rank;
   } way_type;

   // One row of the set store: all ways plus the round-robin pointer
   typedef struct packed {
      way_type [WAYS-1:0] ways;
      logic [WAY_W-1:0]   fifo_ptr;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // Outcome of one access
   typedef struct packed {
      logic hit;
      logic mem_write;
   } outcome_type;

endpackage

>>> hw/rtl/sact_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sact_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last data while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sact_set_update.sv
// Lookup, victim choice and row update for one set read from the store.
module sact_set_update (
   input  sact_pkg::row_type                 row_in,
   input  logic                              is_write,
   input  logic [sact_pkg::TAG_W-1:0]        block,
   input  logic                              write_back,
   input  logic                              policy,
   input  logic [sact_pkg::WCNT_W-1:0]       nways,
   output sact_pkg::row_type                 row_out,
   output sact_pkg::outcome_type             outcome
);

   logic [sact_pkg::WAYS-1:0]    active;
   logic                         hit;
   logic [sact_pkg::WAY_W-1:0]   hit_way;
   logic                         found_inv;
   logic [sact_pkg::WAY_W-1:0]   inv_way;
   logic [sact_pkg::RANK_W-1:0]  best;
   logic [sact_pkg::WAY_W-1:0]   oldest_way;
   logic [sact_pkg::WAY_W-1:0]   fifo_way;
   logic [sact_pkg::WAY_W-1:0]   victim;
   logic [sact_pkg::WAY_W-1:0]   touched;
   logic [sact_pkg::RANK_W:0]    limit;
   sact_pkg::row_type            row;

   always_comb begin
      // Mark the ways in use
      for (int i = 0; i < sact_pkg::WAYS; i++) begin
         active[i] = (i < int'(nways));
      end

      // Find the lowest matching way, and the lowest invalid way
      hit       = 1'b0;
      hit_way   = '0;
      found_inv = 1'b0;
      inv_way   = '0;
      for (int i = sact_pkg::WAYS - 1; i >= 0; i--) begin
         if (active[i] && row_in.ways[i].valid && (row_in.ways[i].tag == block)) begin
            hit     = 1'b1;
            hit_way = sact_pkg::WAY_W'(i);
         end
         if (active[i] && !row_in.ways[i].valid) begin
            found_inv = 1'b1;
            inv_way   = sact_pkg::WAY_W'(i);
         end
      end

      // Oldest way: highest rank, lowest index on ties
      best       = '0;
      oldest_way = '0;
      for (int i = 0; i < sact_pkg::WAYS; i++) begin
         if (active[i] && (row_in.ways[i].rank > best)) begin
            best       = row_in.ways[i].rank;
            oldest_way = sact_pkg::WAY_W'(i);
         end
      end

      // Round-robin way; a stale pointer beyond the ways in use acts as way zero
      fifo_way = (int'(row_in.fifo_ptr) < int'(nways)) ? row_in.fifo_ptr : '0;

      if (policy == sact_pkg::POLICY_FIFO) begin
         victim = fifo_way;
      end else begin
         victim = found_inv ? inv_way : oldest_way;
      end

      touched = hit ? hit_way : victim;
      limit   = hit ? {1'b0, row_in.ways[hit_way].rank} : sact_pkg::RANK_ALL;

      // Age the other valid ways below the limit, then make the touched way newest
      row = row_in;
      for (int i = 0; i < sact_pkg::WAYS; i++) begin
         if (active[i] && (i != int'(touched)) && row_in.ways[i].valid &&
             ({1'b0, row_in.ways[i].rank} < limit) &&
             (row_in.ways[i].rank != sact_pkg::RANK_MAX)) begin
            row.ways[i].rank = row_in.ways[i].rank + 1'b1;
         end
      end
      row.ways[touched].rank = '0;

      if (hit) begin
         if (is_write && write_back) begin
            row.ways[touched].dirty = 1'b1;
         end
      end else begin
         row.ways[touched].tag   = block;
         row.ways[touched].valid = 1'b1;
         row.ways[touched].dirty = write_back && is_write;
         if (policy == sact_pkg::POLICY_FIFO) begin
            row.fifo_ptr = ((int'(fifo_way) + 1) < int'(nways)) ?
                           sact_pkg::WAY_W'(int'(fifo_way) + 1) : '0;
         end
      end

      row_out           = row;
      outcome.hit       = hit;
      outcome.mem_write = (is_write && !write_back) ||
                          (!hit && write_back && row_in.ways[victim].valid &&
                           row_in.ways[victim].dirty);
   end

endmodule

>>> hw/rtl/set_assoc_cache_tag_controller.sv
// Top level of the set-associative cache tag controller: control, counters, registers.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    action, address
//   rsp      out        rsp_valid/stall    hit, memory_read, memory_write, four totals
//   csr      in         csr_write          csr_index, csr_data
//
// Each access first reads its set row from the store, then compares, updates and
// writes the row back. The registered read data of the store sets this order;
// the next access is taken only after the row is written back.
// After reset a clearing pass writes every row to zero; no access is taken during it.
// An access may be taken while a result waits; it then holds in its compare and
// update step until the output register drains.
module set_assoc_cache_tag_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [sact_pkg::ADDR_W-1:0]       req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic                              rsp_memory_read,
   output logic                              rsp_memory_write,
   output logic [sact_pkg::CNT_W-1:0]        rsp_hit_count,
   output logic [sact_pkg::CNT_W-1:0]        rsp_miss_count,
   output logic [sact_pkg::CNT_W-1:0]        rsp_read_count,
   output logic [sact_pkg::CNT_W-1:0]        rsp_write_count,
   input  logic                              csr_write,
   input  logic [sact_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sact_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Configuration
   logic                              policy_ff;
   logic                              wback_ff;
   logic [3:0]                        ways_ff;
   logic [2:0]                        set_bits_ff;

   // Control
   logic                              clear_ff, clear_in;
   logic [sact_pkg::SET_W-1:0]        clear_addr_ff, clear_addr_in;
   logic                              busy_ff, busy_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Access held for its compare and update step
   logic                              action_ff;
   logic [sact_pkg::TAG_W-1:0]        block_ff;
   logic [sact_pkg::SET_W-1:0]        set_ff;

   // Totals and result flags
   logic [sact_pkg::CNT_W-1:0]        hit_total_ff, miss_total_ff;
   logic [sact_pkg::CNT_W-1:0]        read_total_ff, write_total_ff;
   logic                              hit_ff, mem_write_ff;

   logic                              accept;
   logic                              finish;
   logic [sact_pkg::TAG_W-1:0]        req_block;
   logic [sact_pkg::SET_W-1:0]        set_mask;
   logic [sact_pkg::SET_W-1:0]        req_set;
   logic [sact_pkg::WCNT_W-1:0]       nways;
   logic                              ram_wr_en;
   logic [sact_pkg::SET_W-1:0]        ram_wr_addr;
   sact_pkg::row_type                 ram_wr_row;
   sact_pkg::row_type                 rd_row;
   sact_pkg::row_type                 new_row;
   sact_pkg::outcome_type             outcome;

   // Handshakes
   assign req_stall = busy_ff | clear_ff;
   assign accept    = req_valid & ~req_stall;
   assign finish    = busy_ff & (~rsp_valid_ff | ~rsp_stall);

   // Block address and set index under the sets in use
   assign req_block = req_address[sact_pkg::ADDR_W-1:sact_pkg::BLOCK_SHIFT];

   always_comb begin
      for (int b = 0; b < sact_pkg::SET_W; b++) begin
         set_mask[b] = (b < int'(set_bits_ff)) && (b < sact_pkg::SET_BITS);
      end
   end

   assign req_set = req_block[sact_pkg::SET_W-1:0] & set_mask;

   // Ways in use, with zero acting as one and a cap at the ways built
   always_comb begin
      if (ways_ff == 4'd0) begin
         nways = sact_pkg::WCNT_W'(1);
      end else if (int'(ways_ff) > sact_pkg::WAYS) begin
         nways = sact_pkg::WCNT_W'(sact_pkg::WAYS);
      end else begin
         nways = sact_pkg::WCNT_W'(ways_ff);
      end
   end

   // Store write: clearing pass, else the updated row of a finished access
   always_comb begin
      ram_wr_en   = clear_ff | finish;
      ram_wr_addr = clear_ff ? clear_addr_ff : set_ff;
      ram_wr_row  = clear_ff ? '0 : new_row;
   end

   sact_ram #(
      .WIDTH (sact_pkg::ROW_W),
      .DEPTH (sact_pkg::SETS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_row),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (rd_row)
   );

   sact_set_update u_set_update (
      .row_in     (rd_row),
      .is_write   (action_ff == sact_pkg::ACTION_WRITE),
      .block      (block_ff),
      .write_back (wback_ff),
      .policy     (policy_ff),
      .nways      (nways),
      .row_out    (new_row),
      .outcome    (outcome)
   );

   // Next control state
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == sact_pkg::SET_W'(sact_pkg::SETS - 1)) begin
            clear_in = 1'b0;
         end
      end
      busy_in      = accept | (busy_ff & ~finish);
      rsp_valid_in = finish | (rsp_valid_ff & rsp_stall);
   end

   // Control registers, configuration and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= 1'b1;
         clear_addr_ff  <= '0;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         policy_ff      <= sact_pkg::POLICY_LRU;
         wback_ff       <= 1'b1;
         ways_ff        <= 4'd8;
         set_bits_ff    <= 3'd6;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         read_total_ff  <= '0;
         write_total_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               sact_pkg::CSR_POLICY:   policy_ff   <= csr_data[0];
               sact_pkg::CSR_WBACK:    wback_ff    <= csr_data[0];
               sact_pkg::CSR_WAYS:     ways_ff     <= csr_data;
               sact_pkg::CSR_SET_BITS: set_bits_ff <= csr_data[2:0];
               default: ;
            endcase
         end
         if (finish) begin
            if (outcome.hit) begin
               hit_total_ff <= hit_total_ff + 1'b1;
            end else begin
               miss_total_ff <= miss_total_ff + 1'b1;
               read_total_ff <= read_total_ff + 1'b1;
            end
            if (outcome.mem_write) begin
               write_total_ff <= write_total_ff + 1'b1;
            end
         end
      end
   end

   // Payload: capture the access on transfer, the result flags on finish
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         block_ff  <= req_block;
         set_ff    <= req_set;
      end
      if (finish) begin
         hit_ff       <= outcome.hit;
         mem_write_ff <= outcome.mem_write;
      end
   end

   // Result outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_memory_read  = ~hit_ff;
   assign rsp_memory_write = mem_write_ff;
   assign rsp_hit_count    = hit_total_ff;
   assign rsp_miss_count   = miss_total_ff;
   assign rsp_read_count   = read_total_ff;
   assign rsp_write_count  = write_total_ff;

endmodule
